@@ rtl/first_fit_interval_track_assign_top_macros.svh @@
// Assertion shorthands shared by the RTL files.
`ifndef FIRST_FIT_INTERVAL_TRACK_ASSIGN_TOP_MACROS_SVH
`define FIRST_FIT_INTERVAL_TRACK_ASSIGN_TOP_MACROS_SVH

// Same-cycle implication, muted while reset is asserted.
`define FITA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, muted while reset is asserted.
`define FITA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/fita_pkg.sv @@
package fita_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int MAX_TRACKS  = 16;
	localparam int ADDR_WIDTH  = 16;

	localparam int IDX_W     = $clog2(MAX_ENTRIES);
	localparam int ENT_CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int TRK_W     = $clog2(MAX_TRACKS);
	localparam int TRK_CNT_W = $clog2(MAX_TRACKS + 1);

	typedef logic [ADDR_WIDTH-1:0] addr_t;
	typedef logic [TRK_W-1:0]      track_t;
	typedef logic [TRK_CNT_W-1:0]  track_cnt_t;
	typedef logic [ENT_CNT_W-1:0]  entry_cnt_t;
	typedef logic [IDX_W-1:0]      entry_idx_t;

	// One stored interval.
	typedef struct packed {
		addr_t  first;
		addr_t  last;
		track_t track;
	} entry_t;

	// Sequencer to scan unit.
	typedef struct packed {
		logic       start;
		addr_t      lo;
		addr_t      hi;
		entry_cnt_t count;
	} scan_cmd_t;

	// Scan unit to sequencer.
	typedef struct packed {
		logic                  done;
		logic [MAX_TRACKS-1:0] busy;
	} scan_sts_t;

endpackage

@@ rtl/fita_in_if.sv @@
interface fita_in_if;
	import fita_pkg::*;

	logic  valid;
	logic  ready;
	addr_t source_address;
	addr_t target_address;
	logic  begin_set;

	modport source (output valid, source_address, target_address, begin_set, input ready);
	modport sink (input valid, source_address, target_address, begin_set, output ready);
endinterface

@@ rtl/fita_out_if.sv @@
interface fita_out_if;
	import fita_pkg::*;

	logic       valid;
	logic       ready;
	track_t     track_index;
	logic       opened_track;
	logic       rejected;
	track_cnt_t tracks_in_use;

	modport source (output valid, track_index, opened_track, rejected, tracks_in_use,
		input ready);
	modport sink (input valid, track_index, opened_track, rejected, tracks_in_use,
		output ready);
endinterface

@@ rtl/first_fit_interval_track_assign_top.sv @@
// First-fit interval track assignment.
// req carries one jump per transaction (source_address, target_address,
// begin_set); rsp returns one result transaction per request (track_index,
// opened_track, rejected, tracks_in_use). Both channels are valid/ready.
// The jump becomes the inclusive interval [min, max]; begin_set empties the
// table and closes every track before the insert. One comparator then walks
// the stored entries, one per cycle out of the entry memory, marking each
// track holding an overlapping interval. The lowest open track left unmarked
// is taken, otherwise a new track is opened, otherwise the interval is
// rejected (also when the table is full).
// The memory walk sets the latency. One transaction is processed at a time:
// req.ready is high only while the sequencer is idle, so a new request is
// taken only once the last one has left the pick step.
// The result sits in an output register; a stalled receiver lets the block
// take and process the next request, which then holds in the pick step until
// the register is free. Reset (arst_n low) empties the table and closes all
// tracks; memory contents are left as they are and never read before written.
`include "first_fit_interval_track_assign_top_macros.svh"

module first_fit_interval_track_assign_top (
	input  logic              clk,
	input  logic              arst_n,
	fita_in_if.sink           req,
	fita_out_if.source        rsp
);
	import fita_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_PICK} state_t;

	state_t     state_q;
	addr_t      lo_q;
	addr_t      hi_q;
	entry_cnt_t entry_cnt_q;
	track_cnt_t track_cnt_q;

	logic       out_valid_q;
	track_t     out_track_q;
	logic       out_opened_q;
	logic       out_rej_q;
	track_cnt_t out_used_q;

	scan_cmd_t  scan_cmd;
	scan_sts_t  scan_sts;
	entry_idx_t rd_addr;
	entry_t     rd_data;
	entry_t     wr_data;

	logic                  accept;
	logic                  slot_free;
	logic                  fire;
	logic [MAX_TRACKS-1:0] free;
	logic                  found;
	track_t                first_free;
	logic                  table_full;
	logic                  tracks_full;
	logic                  reject;
	logic                  opened;
	track_t                chosen;
	addr_t                 in_lo;
	addr_t                 in_hi;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign slot_free = !out_valid_q || rsp.ready;
	assign fire      = (state_q == ST_PICK) && slot_free;

	assign in_lo = (req.source_address < req.target_address) ?
		req.source_address : req.target_address;
	assign in_hi = (req.source_address < req.target_address) ?
		req.target_address : req.source_address;

	assign scan_cmd.start = accept;
	assign scan_cmd.lo    = lo_q;
	assign scan_cmd.hi    = hi_q;
	assign scan_cmd.count = entry_cnt_q;

	fita_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (scan_cmd),
		.sts    (scan_sts),
		.raddr  (rd_addr),
		.rdata  (rd_data)
	);

	// Pick the lowest open track that the walk left unmarked.
	always_comb begin
		free       = '0;
		first_free = '0;
		for (int t = 0; t < MAX_TRACKS; t++) begin
			free[t] = !scan_sts.busy[t] && (TRK_CNT_W'(t) < track_cnt_q);
		end
		for (int t = MAX_TRACKS - 1; t >= 0; t--) begin
			if (free[t]) begin
				first_free = TRK_W'(t);
			end
		end
	end

	assign found       = |free;
	assign table_full  = (entry_cnt_q == ENT_CNT_W'(MAX_ENTRIES));
	assign tracks_full = (track_cnt_q == TRK_CNT_W'(MAX_TRACKS));
	assign reject      = table_full || (!found && tracks_full);
	assign opened      = !table_full && !found && !tracks_full;
	assign chosen      = found ? first_free : track_cnt_q[TRK_W-1:0];

	assign wr_data.first = lo_q;
	assign wr_data.last  = hi_q;
	assign wr_data.track = chosen;

	fita_table u_table (
		.clk   (clk),
		.we    (fire && !reject),
		.waddr (entry_cnt_q[IDX_W-1:0]),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			entry_cnt_q  <= '0;
			track_cnt_q  <= '0;
			out_valid_q  <= 1'b0;
			lo_q         <= '0;
			hi_q         <= '0;
			out_track_q  <= '0;
			out_opened_q <= 1'b0;
			out_rej_q    <= 1'b0;
			out_used_q   <= '0;
		end else begin
			// Drop the result once taken, unless a new one replaces it.
			if (out_valid_q && rsp.ready && !fire) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						lo_q    <= in_lo;
						hi_q    <= in_hi;
						// Drop the whole set before this insert.
						if (req.begin_set) begin
							entry_cnt_q <= '0;
							track_cnt_q <= '0;
						end
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_sts.done) begin
						state_q <= ST_PICK;
					end
				end
				ST_PICK: begin
					// Hold until the output register can take the result.
					if (slot_free) begin
						if (!reject) begin
							entry_cnt_q <= entry_cnt_q + 1'b1;
						end
						if (opened) begin
							track_cnt_q <= track_cnt_q + 1'b1;
						end
						out_valid_q  <= 1'b1;
						out_track_q  <= reject ? '0 : chosen;
						out_opened_q <= opened;
						out_rej_q    <= reject;
						out_used_q   <= track_cnt_q + TRK_CNT_W'(opened);
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.track_index   = out_track_q;
	assign rsp.opened_track  = out_opened_q;
	assign rsp.rejected      = out_rej_q;
	assign rsp.tracks_in_use = out_used_q;

	`FITA_ASSERT_NEXT(a_store_bumps_count, clk, arst_n, fire && !reject, entry_cnt_q == $past(entry_cnt_q) + 1'b1, "stored interval did not advance the entry count")
	`FITA_ASSERT_IMPLY(a_reject_clean, clk, arst_n, out_valid_q && out_rej_q, out_track_q == '0 && !out_opened_q, "rejected result carries a track")
	`FITA_ASSERT_IMPLY(a_open_is_last, clk, arst_n, out_valid_q && out_opened_q, out_used_q == TRK_CNT_W'(out_track_q) + 1'b1, "opened track is not the newest")
	`FITA_ASSERT_IMPLY(a_done_in_scan, clk, arst_n, scan_sts.done, state_q == ST_SCAN, "scan finished outside the scan step")
endmodule

@@ rtl/fita_table.sv @@
module fita_table (
	input  logic                 clk,
	input  logic                 we,
	input  fita_pkg::entry_idx_t waddr,
	input  fita_pkg::entry_t     wdata,
	input  fita_pkg::entry_idx_t raddr,
	output fita_pkg::entry_t     rdata
);
	import fita_pkg::*;

	entry_t mem [MAX_ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/fita_scan.sv @@
module fita_scan (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fita_pkg::scan_cmd_t  cmd,
	output fita_pkg::scan_sts_t  sts,
	output fita_pkg::entry_idx_t raddr,
	input  fita_pkg::entry_t     rdata
);
	import fita_pkg::*;

	entry_cnt_t            idx_q;
	logic                  active_q;
	logic                  pend_s1;
	logic [MAX_TRACKS-1:0] busy_q;
	logic                  more;
	logic                  hit;

	assign more  = idx_q < cmd.count;
	assign raddr = idx_q[IDX_W-1:0];
	// Single overlap comparator, fed one stored entry per cycle.
	assign hit   = (rdata.first <= cmd.hi) && (rdata.last >= cmd.lo);

	assign sts.done = active_q && !pend_s1 && !more;
	assign sts.busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			active_q <= 1'b0;
			pend_s1  <= 1'b0;
			busy_q   <= '0;
		end else if (cmd.start) begin
			idx_q    <= '0;
			active_q <= 1'b1;
			pend_s1  <= 1'b0;
			busy_q   <= '0;
		end else if (active_q) begin
			// Issue the next read while the previous entry is compared.
			if (more) begin
				idx_q   <= idx_q + 1'b1;
				pend_s1 <= 1'b1;
			end else begin
				pend_s1 <= 1'b0;
			end
			if (pend_s1 && hit) begin
				busy_q[rdata.track] <= 1'b1;
			end
			if (sts.done) begin
				active_q <= 1'b0;
			end
		end
	end
endmodule

@@ bench/tb_first_fit_interval_track_assign_top.sv @@
module tb_first_fit_interval_track_assign_top;
	import fita_pkg::*;

	// One result transaction as seen on rsp.
	typedef struct packed {
		track_t     track_index;
		logic       opened_track;
		logic       rejected;
		track_cnt_t tracks_in_use;
	} assignment_t;

	// Shapes of the random jump sets.
	typedef enum {SPREAD, NESTED, CLUSTER, SCATTER, NOISE} jump_mix_t;

	// Keeps a private copy of the interval table and the track count, predicts
	// the assignment for every accepted jump and checks results in order.
	class track_scoreboard;
		addr_t       first_addr[MAX_ENTRIES];
		addr_t       last_addr[MAX_ENTRIES];
		track_t      owner[MAX_ENTRIES];
		int          entries;
		int          tracks;
		assignment_t expected_q[$];
		int          mismatches;

		function new();
			entries    = 0;
			tracks     = 0;
			mismatches = 0;
		endfunction

		// Work out where first fit puts the jump, update the shadow table.
		function void place_jump(addr_t src, addr_t dst, logic restart);
			addr_t                 lo;
			addr_t                 hi;
			logic [MAX_TRACKS-1:0] busy;
			assignment_t           a;
			bit                    found;
			int                    i;
			int                    t;

			lo    = (src < dst) ? src : dst;
			hi    = (src < dst) ? dst : src;
			a     = '0;
			found = 1'b0;
			if (restart) begin
				entries = 0;
				tracks  = 0;
			end
			if (entries >= MAX_ENTRIES) begin
				a.rejected = 1'b1;
			end else begin
				busy = '0;
				for (i = 0; i < entries; i++)
					if (first_addr[i] <= hi && last_addr[i] >= lo)
						busy[owner[i]] = 1'b1;
				for (t = 0; t < tracks; t++)
					if (!found && !busy[t]) begin
						a.track_index = track_t'(t);
						found = 1'b1;
					end
				if (!found) begin
					if (tracks < MAX_TRACKS) begin
						a.track_index  = track_t'(tracks);
						a.opened_track = 1'b1;
						tracks++;
						found = 1'b1;
					end else begin
						a.rejected = 1'b1;
					end
				end
				if (found) begin
					first_addr[entries] = lo;
					last_addr[entries]  = hi;
					owner[entries]      = a.track_index;
					entries++;
				end
			end
			a.tracks_in_use = track_cnt_t'(tracks);
			expected_q.insert(expected_q.size(), a);
		endfunction

		function void check_assignment(assignment_t got);
			assignment_t want;

			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with nothing outstanding: track %0d opened %0b rej %0b in_use %0d",
						$realtime, got.track_index, got.opened_track, got.rejected,
						got.tracks_in_use);
				return;
			end
			want = expected_q.pop_front();
			if (got.track_index !== want.track_index || got.opened_track !== want.opened_track ||
					got.rejected !== want.rejected || got.tracks_in_use !== want.tracks_in_use) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: track %0d/%0d opened %0b/%0b rej %0b/%0b in_use %0d/%0d (exp/act)",
						$realtime, want.track_index, got.track_index, want.opened_track,
						got.opened_track, want.rejected, got.rejected, want.tracks_in_use,
						got.tracks_in_use);
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	fita_in_if  req();
	fita_out_if rsp();

	track_scoreboard board = new();

	// Set by the sender for a stretch of the random part: neither side idles then.
	bit calm;
	int results_seen;
	int hold_left;

	first_fit_interval_track_assign_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Guard against a hung block: far beyond the slowest legal run.
	initial begin
		#10_000_000;
		$display("Some tests failed");
		$finish;
	end

	// Offer one jump from the falling edge, hold it until the block takes it,
	// then note the transaction with the scoreboard. Return at a falling edge
	// so the next call can drive straight away.
	task automatic send_jump(input addr_t src, input addr_t dst, input logic restart);
		while (!calm && $urandom_range(0, 99) < 7) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid          <= 1'b1;
		req.source_address <= src;
		req.target_address <= dst;
		req.begin_set      <= restart;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		board.place_jump(src, dst, restart);
		@(negedge clk);
	endtask

	// Receiver: drive ready at the falling edge, sample the result at the
	// rising edge. After the hundredth result, hold off for a long stretch so
	// the output register fills and req.ready drops while the sender keeps
	// offering.
	initial begin
		assignment_t got;

		rsp.ready    = 1'b0;
		results_seen = 0;
		hold_left    = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				rsp.ready <= 1'b0;
				hold_left--;
			end else begin
				rsp.ready <= calm || ($urandom_range(0, 99) >= 7);
			end
			@(posedge clk);
			if (rsp.valid && rsp.ready) begin
				got.track_index   = rsp.track_index;
				got.opened_track  = rsp.opened_track;
				got.rejected      = rsp.rejected;
				got.tracks_in_use = rsp.tracks_in_use;
				board.check_assignment(got);
				results_seen++;
				if (results_seen == 100)
					hold_left = 400;
			end
		end
	end

	initial begin
		int        rnd_done;
		int        len;
		int        k;
		int        pick;
		jump_mix_t mix;
		addr_t     src;
		addr_t     dst;
		addr_t     swap;
		addr_t     centre;
		logic      restart;

		arst_n             = 1'b0;
		calm               = 1'b0;
		req.valid          = 1'b0;
		req.source_address = '0;
		req.target_address = '0;
		req.begin_set      = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: address extremes, reversed order, single-address intervals,
		// reuse of a lower track once it is clear, and inclusive end points.
		send_jump(16'h0000, 16'h0000, 1'b1);
		send_jump(16'hFFFF, 16'hFFFF, 1'b0);
		send_jump(16'hFFFF, 16'h0000, 1'b0);
		send_jump(16'h0000, 16'hFFFF, 1'b0);
		send_jump(16'h8000, 16'h8000, 1'b0);
		send_jump(16'h5678, 16'h1234, 1'b0);
		send_jump(16'h5678, 16'h7000, 1'b0);

		// Directed: seventeen intervals that all share one point, so every
		// track opens and the last one finds the tracks exhausted.
		send_jump(16'h7FFF, 16'h8000, 1'b1);
		for (k = 1; k <= MAX_TRACKS; k++) begin
			src = addr_t'(16'h7FFF - k * 16'h07FF);
			dst = addr_t'(16'h8000 + k * 16'h07FF);
			if (k % 2)
				send_jump(dst, src, 1'b0);
			else
				send_jump(src, dst, 1'b0);
		end

		// Random: sets of jumps, most opened by begin_set. Long sparse sets
		// fill the table; nested sets exhaust the tracks; the rest mix.
		rnd_done = 0;
		while (rnd_done < 950) begin
			pick = $urandom_range(0, 9);
			mix  = (pick < 4) ? SPREAD : (pick < 6) ? NESTED : (pick < 8) ? CLUSTER :
				(pick < 9) ? SCATTER : NOISE;
			case (mix)
				SPREAD: begin
					len    = ($urandom_range(0, 2) == 0) ? $urandom_range(66, 75)
						: $urandom_range(20, 60);
					centre = '0;
				end
				NESTED: begin
					len    = $urandom_range(12, 24);
					centre = addr_t'($urandom_range(16'h1000, 16'hEFFF));
				end
				CLUSTER: begin
					len    = $urandom_range(10, 40);
					centre = addr_t'($urandom_range(0, 16'hF7FF));
				end
				default: begin
					len    = $urandom_range(5, 30);
					centre = '0;
				end
			endcase
			for (k = 0; k < len && rnd_done < 950; k++) begin
				case (mix)
					SPREAD: begin
						src = addr_t'($urandom_range(0, 16'hFFFF));
						dst = addr_t'(src + $urandom_range(0, 255));
					end
					NESTED: begin
						src = addr_t'(centre - $urandom_range(0, 16'h0FFF));
						dst = addr_t'(centre + $urandom_range(0, 16'h0FFF));
					end
					CLUSTER: begin
						src = addr_t'(centre + $urandom_range(0, 16'h07FF));
						dst = addr_t'(centre + $urandom_range(0, 16'h07FF));
					end
					default: begin
						src = addr_t'($urandom_range(0, 16'hFFFF));
						dst = addr_t'($urandom_range(0, 16'hFFFF));
					end
				endcase
				if ($urandom_range(0, 15) == 0)
					dst = src;
				if ($urandom_range(0, 1)) begin
					swap = src;
					src  = dst;
					dst  = swap;
				end
				// Leave the odd set without a begin_set so it builds on the last one.
				if (k == 0)
					restart = ($urandom_range(0, 9) != 0);
				else if (mix == NOISE)
					restart = ($urandom_range(0, 7) == 0);
				else
					restart = 1'b0;
				calm = (rnd_done >= 400 && rnd_done < 600);
				send_jump(src, dst, restart);
				rnd_done++;
			end
		end
		req.valid <= 1'b0;
		calm = 1'b0;

		// Drain: wait for every outstanding result, then keep watching the clock
		// to catch any stray transaction.
		while (board.pending() != 0)
			@(posedge clk);
		repeat (MAX_ENTRIES + 16) @(posedge clk);
		if (board.mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
